// ===== src/fptc_pkg.sv =====
package fptc_pkg;

   // Configuration register indexes on the write port.
   localparam logic [2:0] CSR_WHEEL_BASE       = 3'd0;
   localparam logic [2:0] CSR_DIST_MID         = 3'd1;
   localparam logic [2:0] CSR_DIST_SPAN        = 3'd2;
   localparam logic [2:0] CSR_ANGLE_SPAN       = 3'd3;
   localparam logic [2:0] CSR_DIST_GAIN_SMALL  = 3'd4;
   localparam logic [2:0] CSR_DIST_GAIN_LARGE  = 3'd5;
   localparam logic [2:0] CSR_ANGLE_GAIN_SMALL = 3'd6;
   localparam logic [2:0] CSR_ANGLE_GAIN_LARGE = 3'd7;

   // Iteration counts of the shared loops, and the width of the step counter.
   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 49;
   localparam int CORDIC_STEPS = 16;
   localparam int RULE_COUNT   = 4;
   localparam int CNT_W        = 6;

   localparam logic signed [32:0] INV_TWO_PI_Q32  = 33'sd683565276;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [33:0] QUARTER_TURN    = 34'sd1073741824;
   localparam logic signed [33:0] HALF_TURN       = 34'sd2147483648;
   localparam logic signed [33:0] ROUND_Q30       = 34'sd8192;
   localparam logic [16:0]        Q16_ONE         = 17'd65536;
   localparam logic signed [31:0] INT32_MAX       = 32'sh7fffffff;
   localparam logic signed [31:0] INT32_MIN       = 32'sh80000000;

   typedef struct packed {
      logic [30:0] wheel_base;
      logic [30:0] dist_mid;
      logic [30:0] dist_span;
      logic [30:0] angle_span;
      logic [17:0] dist_gain_small;
      logic [17:0] dist_gain_large;
      logic [17:0] angle_gain_small;
      logic [17:0] angle_gain_large;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_DIFF, OP_SQ_X, OP_SQ_Y, OP_SUM, OP_SQRT, OP_DIST,
      OP_MUDE, OP_DIV, OP_MUDE_DONE, OP_MUTE, OP_MUTE_DONE, OP_MUTE_L,
      OP_R_PD, OP_R_PT, OP_R_W, OP_R_LR, OP_R_L, OP_R_R, OP_R_ACC,
      OP_VEL, OP_OMEGA, OP_CORD_INIT, OP_CORDIC, OP_TRIG,
      OP_MUL_X, OP_MUL_Y, OP_POSE
   } dp_op_type;

   typedef struct packed {
      dp_op_type        op;
      logic [CNT_W-1:0] cnt;
   } dp_cmd_type;

   typedef struct packed {
      logic mude_div;
   } dp_status_type;

   // Arctangent of 2^-i in units of 2^-32 turn.
   function automatic logic [29:0] atan_turn(input logic [3:0] i);
      logic [29:0] r;
      case (i)
         4'd0:    r = 30'd536870912;
         4'd1:    r = 30'd316933406;
         4'd2:    r = 30'd167458907;
         4'd3:    r = 30'd85004756;
         4'd4:    r = 30'd42667331;
         4'd5:    r = 30'd21354465;
         4'd6:    r = 30'd10679838;
         4'd7:    r = 30'd5340245;
         4'd8:    r = 30'd2670163;
         4'd9:    r = 30'd1335087;
         4'd10:   r = 30'd667544;
         4'd11:   r = 30'd333772;
         4'd12:   r = 30'd166886;
         4'd13:   r = 30'd83443;
         4'd14:   r = 30'd41722;
         4'd15:   r = 30'd20861;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > 68'(INT32_MAX)) begin
         r = INT32_MAX;
      end else if (v < 68'(INT32_MIN)) begin
         r = INT32_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== src/fptc_ctrl.sv =====
module fptc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   out_free,
   input  fptc_pkg::dp_status_type status,
   output fptc_pkg::dp_cmd_type   cmd,
   output logic                   done
);

   typedef enum logic [30:0] {
      ST_IDLE      = 31'h00000001,
      ST_DIFF      = 31'h00000002,
      ST_SQX       = 31'h00000004,
      ST_SQY       = 31'h00000008,
      ST_SUM       = 31'h00000010,
      ST_SQRT      = 31'h00000020,
      ST_DIST      = 31'h00000040,
      ST_MUDE      = 31'h00000080,
      ST_DIVA      = 31'h00000100,
      ST_MUDE_DONE = 31'h00000200,
      ST_MUTE      = 31'h00000400,
      ST_DIVB      = 31'h00000800,
      ST_MUTE_DONE = 31'h00001000,
      ST_MUTE_L    = 31'h00002000,
      ST_R_PD      = 31'h00004000,
      ST_R_PT      = 31'h00008000,
      ST_R_W       = 31'h00010000,
      ST_R_LR      = 31'h00020000,
      ST_R_L       = 31'h00040000,
      ST_R_R       = 31'h00080000,
      ST_R_ACC     = 31'h00100000,
      ST_VEL       = 31'h00200000,
      ST_DIVC      = 31'h00400000,
      ST_OMEGA     = 31'h00800000,
      ST_CORD_INIT = 31'h01000000,
      ST_CORDIC    = 31'h02000000,
      ST_TRIG      = 31'h04000000,
      ST_MUL_X     = 31'h08000000,
      ST_MUL_Y     = 31'h10000000,
      ST_POSE      = 31'h20000000,
      ST_OUT       = 31'h40000000
   } state_type;

   localparam logic [fptc_pkg::CNT_W-1:0] SQRT_LAST =
      fptc_pkg::CNT_W'(fptc_pkg::SQRT_STEPS - 1);
   localparam logic [fptc_pkg::CNT_W-1:0] DIV_LAST =
      fptc_pkg::CNT_W'(fptc_pkg::DIV_STEPS - 1);
   localparam logic [fptc_pkg::CNT_W-1:0] CORDIC_LAST =
      fptc_pkg::CNT_W'(fptc_pkg::CORDIC_STEPS - 1);
   localparam logic [fptc_pkg::CNT_W-1:0] RULE_LAST =
      fptc_pkg::CNT_W'(fptc_pkg::RULE_COUNT - 1);

   state_type state_ff, state_in;
   logic [fptc_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign cmd.cnt    = cnt_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = fptc_pkg::OP_NONE;
      done     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = fptc_pkg::OP_LOAD;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.op   = fptc_pkg::OP_DIFF;
            state_in = ST_SQX;
         end
         ST_SQX: begin
            cmd.op   = fptc_pkg::OP_SQ_X;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.op   = fptc_pkg::OP_SQ_Y;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = fptc_pkg::OP_SUM;
            cnt_in   = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op = fptc_pkg::OP_SQRT;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) begin
               state_in = ST_DIST;
            end
         end
         ST_DIST: begin
            cmd.op   = fptc_pkg::OP_DIST;
            state_in = ST_MUDE;
         end
         ST_MUDE: begin
            cmd.op = fptc_pkg::OP_MUDE;
            cnt_in = '0;
            state_in = status.mude_div ? ST_DIVA : ST_MUTE;
         end
         ST_DIVA: begin
            cmd.op = fptc_pkg::OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_MUDE_DONE;
            end
         end
         ST_MUDE_DONE: begin
            cmd.op   = fptc_pkg::OP_MUDE_DONE;
            state_in = ST_MUTE;
         end
         ST_MUTE: begin
            cmd.op   = fptc_pkg::OP_MUTE;
            cnt_in   = '0;
            state_in = ST_DIVB;
         end
         ST_DIVB: begin
            cmd.op = fptc_pkg::OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_MUTE_DONE;
            end
         end
         ST_MUTE_DONE: begin
            cmd.op   = fptc_pkg::OP_MUTE_DONE;
            state_in = ST_MUTE_L;
         end
         ST_MUTE_L: begin
            cmd.op   = fptc_pkg::OP_MUTE_L;
            cnt_in   = '0;
            state_in = ST_R_PD;
         end
         ST_R_PD: begin
            cmd.op   = fptc_pkg::OP_R_PD;
            state_in = ST_R_PT;
         end
         ST_R_PT: begin
            cmd.op   = fptc_pkg::OP_R_PT;
            state_in = ST_R_W;
         end
         ST_R_W: begin
            cmd.op   = fptc_pkg::OP_R_W;
            state_in = ST_R_LR;
         end
         ST_R_LR: begin
            cmd.op   = fptc_pkg::OP_R_LR;
            state_in = ST_R_L;
         end
         ST_R_L: begin
            cmd.op   = fptc_pkg::OP_R_L;
            state_in = ST_R_R;
         end
         ST_R_R: begin
            cmd.op   = fptc_pkg::OP_R_R;
            state_in = ST_R_ACC;
         end
         ST_R_ACC: begin
            cmd.op = fptc_pkg::OP_R_ACC;
            cnt_in = cnt_ff + 1'b1;
            state_in = (cnt_ff == RULE_LAST) ? ST_VEL : ST_R_PD;
         end
         ST_VEL: begin
            cmd.op   = fptc_pkg::OP_VEL;
            cnt_in   = '0;
            state_in = ST_DIVC;
         end
         ST_DIVC: begin
            cmd.op = fptc_pkg::OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_OMEGA;
            end
         end
         ST_OMEGA: begin
            cmd.op   = fptc_pkg::OP_OMEGA;
            state_in = ST_CORD_INIT;
         end
         ST_CORD_INIT: begin
            cmd.op   = fptc_pkg::OP_CORD_INIT;
            cnt_in   = '0;
            state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            cmd.op = fptc_pkg::OP_CORDIC;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CORDIC_LAST) begin
               state_in = ST_TRIG;
            end
         end
         ST_TRIG: begin
            cmd.op   = fptc_pkg::OP_TRIG;
            state_in = ST_MUL_X;
         end
         ST_MUL_X: begin
            cmd.op   = fptc_pkg::OP_MUL_X;
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            cmd.op   = fptc_pkg::OP_MUL_Y;
            state_in = ST_POSE;
         end
         ST_POSE: begin
            cmd.op   = fptc_pkg::OP_POSE;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== src/fptc_dp.sv =====
module fptc_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  fptc_pkg::cfg_type         cfg,
   input  logic signed [31:0]        ref_x,
   input  logic signed [31:0]        ref_y,
   input  logic signed [31:0]        ref_heading,
   input  fptc_pkg::dp_cmd_type      cmd,
   output fptc_pkg::dp_status_type   status,
   output logic signed [31:0]        est_x,
   output logic signed [31:0]        est_y,
   output logic signed [31:0]        est_heading
);

   logic               started_ff, started_in;
   logic signed [31:0] rx_ff, rx_in, ry_ff, ry_in, rh_ff, rh_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in, ph_ff, ph_in;
   logic [32:0]        ax_ff, ax_in, ay_ff, ay_in;
   logic               huge_ff, huge_in;
   logic signed [31:0] te_ff, te_in;
   logic signed [65:0] prod_ff, prod_in;
   logic [63:0]        acc_ff, acc_in, root_ff, root_in, bit_ff, bit_in;
   logic [30:0]        dist_ff, dist_in;
   logic [30:0]        rem_ff, rem_in, den_ff, den_in;
   logic [48:0]        quo_ff, quo_in;
   logic               neg_ff, neg_in;
   logic [16:0]        mude_ff, mude_in;
   logic signed [31:0] mute_s_ff, mute_s_in, mute_l_ff, mute_l_in;
   logic signed [31:0] pd_ff, pd_in, pt_ff, pt_in, wgt_ff, wgt_in;
   logic signed [31:0] vl_ff, vl_in, vr_ff, vr_in, vel_ff, vel_in, omega_ff, omega_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic               flip_ff, flip_in;
   logic signed [20:0] cs_ff, cs_in, sn_ff, sn_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p, prod_sh;
   logic signed [31:0] prod_sat;
   logic signed [32:0] dx_w, dy_w;
   logic [32:0]        adx_w, ady_w;
   logic [63:0]        sq_trial;
   logic [31:0]        div_sh;
   logic               div_ge;
   logic signed [49:0] div_q;
   logic signed [32:0] mude_num;
   logic [30:0]        te_span;
   logic [32:0]        te_abs;
   logic signed [33:0] te_num, te_neg;
   logic [16:0]        mud_sel;
   logic signed [31:0] mut_sel;
   logic [17:0]        kd_sel, kt_sel;
   logic signed [32:0] vsum, vdiff;
   logic [32:0]        vmag;
   logic signed [33:0] phz, cxs, cys, atz, xr, yr;
   logic [3:0]         step_idx;

   assign mul_p    = mul_a * mul_b;
   assign prod_sh  = prod_ff >>> 16;
   assign prod_sat = fptc_pkg::sat32(68'(prod_sh));

   assign dx_w  = 33'(rx_ff) - 33'(px_ff);
   assign dy_w  = 33'(ry_ff) - 33'(py_ff);
   assign adx_w = dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
   assign ady_w = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);

   assign sq_trial = root_ff + bit_ff;

   // Restoring divider: one quotient bit per cycle.
   assign div_sh = {rem_ff, quo_ff[48]};
   assign div_ge = div_sh >= {1'b0, den_ff};
   assign div_q  = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

   assign mude_num = $signed({2'b0, cfg.dist_mid}) - $signed({2'b0, dist_ff});
   assign status.mude_div = !mude_num[32] && (mude_num != '0)
                            && (mude_num[31:0] < {1'b0, cfg.dist_span});

   assign te_span = (cfg.angle_span == '0) ? 31'd1 : cfg.angle_span;
   assign te_abs  = te_ff[31] ? 33'(-(33'(te_ff))) : 33'(te_ff);
   assign te_num  = $signed({3'b0, te_span}) - $signed({1'b0, te_abs});
   assign te_neg  = -te_num;

   // Rule j: bit 1 picks the distance term, bit 0 the heading term.
   assign mud_sel = cmd.cnt[1] ? (fptc_pkg::Q16_ONE - mude_ff) : mude_ff;
   assign mut_sel = cmd.cnt[0] ? mute_l_ff : mute_s_ff;
   assign kd_sel  = cmd.cnt[1] ? cfg.dist_gain_large : cfg.dist_gain_small;
   assign kt_sel  = cmd.cnt[0] ? cfg.angle_gain_large : cfg.angle_gain_small;

   assign vsum  = 33'(vl_ff) + 33'(vr_ff);
   assign vdiff = 33'(vl_ff) - 33'(vr_ff);
   assign vmag  = vdiff[32] ? 33'(-vdiff) : 33'(vdiff);

   assign phz      = 34'($signed(prod_ff[47:16]));
   assign step_idx = cmd.cnt[3:0];
   assign cxs      = cx_ff >>> step_idx;
   assign cys      = cy_ff >>> step_idx;
   assign atz      = $signed({4'b0, fptc_pkg::atan_turn(step_idx)});
   assign xr       = (cx_ff + fptc_pkg::ROUND_Q30) >>> 14;
   assign yr       = (cy_ff + fptc_pkg::ROUND_Q30) >>> 14;

   always_comb begin
      started_in = started_ff;
      rx_in = rx_ff;  ry_in = ry_ff;  rh_in = rh_ff;
      px_in = px_ff;  py_in = py_ff;  ph_in = ph_ff;
      ax_in = ax_ff;  ay_in = ay_ff;  huge_in = huge_ff;  te_in = te_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;  root_in = root_ff;  bit_in = bit_ff;  dist_in = dist_ff;
      rem_in = rem_ff;  quo_in = quo_ff;  den_in = den_ff;  neg_in = neg_ff;
      mude_in = mude_ff;  mute_s_in = mute_s_ff;  mute_l_in = mute_l_ff;
      pd_in = pd_ff;  pt_in = pt_ff;  wgt_in = wgt_ff;
      vl_in = vl_ff;  vr_in = vr_ff;  vel_in = vel_ff;  omega_in = omega_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  cz_in = cz_ff;  flip_in = flip_ff;
      cs_in = cs_ff;  sn_in = sn_ff;
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         fptc_pkg::OP_LOAD: begin
            rx_in = ref_x;
            ry_in = ref_y;
            rh_in = ref_heading;
            if (!started_ff) begin
               px_in      = ref_x;
               py_in      = ref_y;
               ph_in      = ref_heading;
               started_in = 1'b1;
            end
         end
         fptc_pkg::OP_DIFF: begin
            ax_in   = adx_w;
            ay_in   = ady_w;
            huge_in = (adx_w[32:31] != 2'b00) || (ady_w[32:31] != 2'b00);
            te_in   = fptc_pkg::sat32(68'(33'(rh_ff) - 33'(ph_ff)));
         end
         fptc_pkg::OP_SQ_X: begin
            mul_a   = $signed({2'b0, ax_ff[30:0]});
            mul_b   = $signed({2'b0, ax_ff[30:0]});
            prod_in = mul_p;
         end
         fptc_pkg::OP_SQ_Y: begin
            acc_in  = prod_ff[63:0];
            mul_a   = $signed({2'b0, ay_ff[30:0]});
            mul_b   = $signed({2'b0, ay_ff[30:0]});
            prod_in = mul_p;
         end
         fptc_pkg::OP_SUM: begin
            acc_in  = acc_ff + prod_ff[63:0];
            root_in = '0;
            bit_in  = 64'h4000000000000000;
         end
         fptc_pkg::OP_SQRT: begin
            if (acc_ff >= sq_trial) begin
               acc_in  = acc_ff - sq_trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         fptc_pkg::OP_DIST: begin
            if (huge_ff || (root_ff[63:31] != '0)) begin
               dist_in = '1;
            end else begin
               dist_in = root_ff[30:0];
            end
         end
         fptc_pkg::OP_MUDE: begin
            mude_in = (mude_num[32] || (mude_num == '0)) ? 17'd0 : fptc_pkg::Q16_ONE;
            rem_in  = '0;
            quo_in  = {2'b0, mude_num[30:0], 16'b0};
            den_in  = cfg.dist_span;
            neg_in  = 1'b0;
         end
         fptc_pkg::OP_DIV: begin
            rem_in = div_ge ? 31'(div_sh - {1'b0, den_ff}) : div_sh[30:0];
            quo_in = {quo_ff[47:0], div_ge};
         end
         fptc_pkg::OP_MUDE_DONE: begin
            mude_in = quo_ff[16:0];
         end
         fptc_pkg::OP_MUTE: begin
            rem_in = '0;
            quo_in = {1'b0, (te_num[33] ? te_neg[31:0] : te_num[31:0]), 16'b0};
            den_in = te_span;
            neg_in = te_num[33];
         end
         fptc_pkg::OP_MUTE_DONE: begin
            mute_s_in = fptc_pkg::sat32(68'(div_q));
         end
         fptc_pkg::OP_MUTE_L: begin
            mute_l_in = fptc_pkg::sat32(68'sd65536 - 68'(mute_s_ff));
            vl_in     = '0;
            vr_in     = '0;
         end
         fptc_pkg::OP_R_PD: begin
            mul_a   = $signed({15'b0, kd_sel});
            mul_b   = $signed({2'b0, dist_ff});
            prod_in = mul_p;
         end
         fptc_pkg::OP_R_PT: begin
            pd_in   = prod_sat;
            mul_a   = $signed({15'b0, kt_sel});
            mul_b   = 33'(te_ff);
            prod_in = mul_p;
         end
         fptc_pkg::OP_R_W: begin
            pt_in   = prod_sat;
            mul_a   = $signed({16'b0, mud_sel});
            mul_b   = 33'(mut_sel);
            prod_in = mul_p;
         end
         fptc_pkg::OP_R_LR: begin
            // The left and right drive terms replace pd and pt.
            wgt_in = prod_sat;
            pd_in  = fptc_pkg::sat32(68'(pd_ff) + 68'(pt_ff));
            pt_in  = fptc_pkg::sat32(68'(pd_ff) - 68'(pt_ff));
         end
         fptc_pkg::OP_R_L: begin
            mul_a   = 33'(wgt_ff);
            mul_b   = 33'(pd_ff);
            prod_in = mul_p;
         end
         fptc_pkg::OP_R_R: begin
            vl_in   = fptc_pkg::sat32(68'(vl_ff) + 68'(prod_sat));
            mul_a   = 33'(wgt_ff);
            mul_b   = 33'(pt_ff);
            prod_in = mul_p;
         end
         fptc_pkg::OP_R_ACC: begin
            vr_in = fptc_pkg::sat32(68'(vr_ff) + 68'(prod_sat));
         end
         fptc_pkg::OP_VEL: begin
            vel_in  = 32'(vsum >>> 1);
            rem_in  = '0;
            quo_in  = {vmag, 16'b0};
            den_in  = (cfg.wheel_base == '0) ? 31'd1 : cfg.wheel_base;
            neg_in  = vdiff[32];
            mul_a   = 33'(ph_ff);
            mul_b   = fptc_pkg::INV_TWO_PI_Q32;
            prod_in = mul_p;
         end
         fptc_pkg::OP_OMEGA: begin
            omega_in = fptc_pkg::sat32(68'(div_q));
         end
         fptc_pkg::OP_CORD_INIT: begin
            cx_in = fptc_pkg::CORDIC_GAIN_Q30;
            cy_in = '0;
            if (phz >= fptc_pkg::QUARTER_TURN) begin
               cz_in   = phz - fptc_pkg::HALF_TURN;
               flip_in = 1'b1;
            end else if (phz < -fptc_pkg::QUARTER_TURN) begin
               cz_in   = phz + fptc_pkg::HALF_TURN;
               flip_in = 1'b1;
            end else begin
               cz_in   = phz;
               flip_in = 1'b0;
            end
         end
         fptc_pkg::OP_CORDIC: begin
            if (!cz_ff[33]) begin
               cx_in = cx_ff - cys;
               cy_in = cy_ff + cxs;
               cz_in = cz_ff - atz;
            end else begin
               cx_in = cx_ff + cys;
               cy_in = cy_ff - cxs;
               cz_in = cz_ff + atz;
            end
         end
         fptc_pkg::OP_TRIG: begin
            cs_in = flip_ff ? -(21'(xr)) : 21'(xr);
            sn_in = flip_ff ? -(21'(yr)) : 21'(yr);
         end
         fptc_pkg::OP_MUL_X: begin
            mul_a   = 33'(vel_ff);
            mul_b   = 33'(cs_ff);
            prod_in = mul_p;
         end
         fptc_pkg::OP_MUL_Y: begin
            px_in   = fptc_pkg::sat32(68'(px_ff) + 68'(prod_sh));
            mul_a   = 33'(vel_ff);
            mul_b   = 33'(sn_ff);
            prod_in = mul_p;
         end
         fptc_pkg::OP_POSE: begin
            py_in = fptc_pkg::sat32(68'(py_ff) + 68'(prod_sh));
            ph_in = fptc_pkg::sat32(68'(ph_ff) + 68'(omega_ff));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         px_ff      <= '0;
         py_ff      <= '0;
         ph_ff      <= '0;
      end else begin
         started_ff <= started_in;
         px_ff      <= px_in;
         py_ff      <= py_in;
         ph_ff      <= ph_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_ff <= rx_in;  ry_ff <= ry_in;  rh_ff <= rh_in;
      ax_ff <= ax_in;  ay_ff <= ay_in;  huge_ff <= huge_in;  te_ff <= te_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;  root_ff <= root_in;  bit_ff <= bit_in;  dist_ff <= dist_in;
      rem_ff <= rem_in;  quo_ff <= quo_in;  den_ff <= den_in;  neg_ff <= neg_in;
      mude_ff <= mude_in;  mute_s_ff <= mute_s_in;  mute_l_ff <= mute_l_in;
      pd_ff <= pd_in;  pt_ff <= pt_in;  wgt_ff <= wgt_in;
      vl_ff <= vl_in;  vr_ff <= vr_in;  vel_ff <= vel_in;  omega_ff <= omega_in;
      cx_ff <= cx_in;  cy_ff <= cy_in;  cz_ff <= cz_in;  flip_ff <= flip_in;
      cs_ff <= cs_in;  sn_ff <= sn_in;
   end

   assign est_x       = px_ff;
   assign est_y       = py_ff;
   assign est_heading = ph_ff;

endmodule

// ===== src/fuzzy_path_tracking_controller.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  ref_x, ref_y, ref_heading (Q16.16)
// rsp_      out        rsp_tvalid/rsp_tready  est_x, est_y, est_heading (Q16.16)
// csr_      in         csr_wr_en              csr_index selects, csr_wdata value
//
// Each item passes through the shared datapath in turn: a 32-step square root, a 49-step
// restoring divider used twice, or three times when the distance membership needs a
// division, the four rules on one shared multiplier, and a 16-step CORDIC.
// Reset is synchronous and returns the registers to their defaults and the pose to zero.
// A stalled result holds in the output register; the next item may be taken meanwhile.
module fuzzy_path_tracking_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // ref_x [31:0], ref_y [63:32], ref_heading [95:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // est_x [31:0], est_y [63:32], est_heading [95:64]
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_wdata
);

   fptc_pkg::cfg_type       cfg_ff, cfg_in;
   fptc_pkg::dp_cmd_type    cmd;
   fptc_pkg::dp_status_type status;
   logic                    done;
   logic                    out_free;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [95:0]             rsp_data_ff, rsp_data_in;
   logic signed [31:0]      est_x, est_y, est_heading;

   // Register writes; each value is masked to its register width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            fptc_pkg::CSR_WHEEL_BASE:       cfg_in.wheel_base       = csr_wdata;
            fptc_pkg::CSR_DIST_MID:         cfg_in.dist_mid         = csr_wdata;
            fptc_pkg::CSR_DIST_SPAN:        cfg_in.dist_span        = csr_wdata;
            fptc_pkg::CSR_ANGLE_SPAN:       cfg_in.angle_span       = csr_wdata;
            fptc_pkg::CSR_DIST_GAIN_SMALL:  cfg_in.dist_gain_small  = csr_wdata[17:0];
            fptc_pkg::CSR_DIST_GAIN_LARGE:  cfg_in.dist_gain_large  = csr_wdata[17:0];
            fptc_pkg::CSR_ANGLE_GAIN_SMALL: cfg_in.angle_gain_small = csr_wdata[17:0];
            fptc_pkg::CSR_ANGLE_GAIN_LARGE: cfg_in.angle_gain_large = csr_wdata[17:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wheel_base       <= 31'd10486;
         cfg_ff.dist_mid         <= 31'd5242880;
         cfg_ff.dist_span        <= 31'd10485760;
         cfg_ff.angle_span       <= 31'd11796480;
         cfg_ff.dist_gain_small  <= 18'd16384;
         cfg_ff.dist_gain_large  <= 18'd32768;
         cfg_ff.angle_gain_small <= 18'd7864;
         cfg_ff.angle_gain_large <= 18'd16384;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The output register frees up in the same cycle that its result is taken.
   assign out_free = !rsp_valid_ff || rsp_tready;

   fptc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .out_free   (out_free),
      .status     (status),
      .cmd        (cmd),
      .done       (done)
   );

   fptc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .ref_x       (req_tdata[31:0]),
      .ref_y       (req_tdata[63:32]),
      .ref_heading (req_tdata[95:64]),
      .cmd         (cmd),
      .status      (status),
      .est_x       (est_x),
      .est_y       (est_y),
      .est_heading (est_heading)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {est_heading, est_y, est_x};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A finished result never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> (!rsp_valid_ff || rsp_tready))
      else $error("result written over a pending transfer");

   // A new item is loaded only on an actual input transfer.
   a_load_on_transfer: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == fptc_pkg::OP_LOAD) |-> (req_tvalid && req_tready))
      else $error("item loaded without an input transfer");

   // A finished result is offered in the next cycle.
   a_done_shows: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_tvalid)
      else $error("finished result not offered");

   // The block takes no input while it still works on an item; checked here during divisions.
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == fptc_pkg::OP_DIV) |-> !req_tready)
      else $error("input ready during a division");

endmodule
